FILE: rtl/vad_pkg.sv
// vad_pkg: shared types, constants and the sample rate table for the depacketizer
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none
package vad_pkg;

    localparam int unsigned HEADER_BYTES = 28;
    localparam logic [19:0] DEFAULT_RATE = 20'd48000;

    typedef enum logic [1:0]
    {
        KIND_UNDECIDED = 2'd0,
        KIND_VBAN      = 2'd1,
        KIND_RAW       = 2'd2
    } kind_t;

    // read request handed from front to back
    typedef struct packed
    {
        logic        valid;
        logic [19:0] rate;
        logic [11:0] stored;
    } read_desc_t;

    // one result item
    typedef struct packed
    {
        logic [15:0] left_sample;
        logic [15:0] right_sample;
        logic        frame_valid;
        logic [19:0] stream_rate_hz;
        logic [11:0] frames_stored;
    } result_t;

    // back part status seen by the front
    typedef struct packed
    {
        logic [2:0] level;
    } back_status_t;

    localparam int unsigned QUEUE_DEPTH = 4;

    // rate index lookup, index valid only up to 20
    function automatic logic [19:0] rate_lookup(input logic [4:0] idx);
        logic [19:0] r;
        begin
            case (idx)
                5'd0:    r = 20'd6000;
                5'd1:    r = 20'd12000;
                5'd2:    r = 20'd24000;
                5'd3:    r = 20'd48000;
                5'd4:    r = 20'd96000;
                5'd5:    r = 20'd192000;
                5'd6:    r = 20'd384000;
                5'd7:    r = 20'd8000;
                5'd8:    r = 20'd16000;
                5'd9:    r = 20'd32000;
                5'd10:   r = 20'd64000;
                5'd11:   r = 20'd128000;
                5'd12:   r = 20'd256000;
                5'd13:   r = 20'd512000;
                5'd14:   r = 20'd11025;
                5'd15:   r = 20'd22050;
                5'd16:   r = 20'd44100;
                5'd17:   r = 20'd88200;
                5'd18:   r = 20'd176400;
                5'd19:   r = 20'd352800;
                5'd20:   r = 20'd705600;
                default: r = 20'd0;
            endcase
            return r;
        end
    endfunction

endpackage
`default_nettype wire

FILE: rtl/vad_if.sv
// vad item and result channel interfaces
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
interface vad_item_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] data_byte;
    logic       last_byte;
    modport source (output valid, command, data_byte, last_byte, input ready);
    modport sink   (input valid, command, data_byte, last_byte, output ready);
endinterface

interface vad_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] left_sample;
    logic [15:0] right_sample;
    logic        frame_valid;
    logic [19:0] stream_rate_hz;
    logic [11:0] frames_stored;
    modport source (output valid, left_sample, right_sample, frame_valid, stream_rate_hz,
                    frames_stored, input ready);
    modport sink   (input valid, left_sample, right_sample, frame_valid, stream_rate_hz,
                    frames_stored, output ready);
endinterface
`default_nettype wire

FILE: rtl/vban_audio_depacketizer_top.sv
// a read item's result passes the read stage, with the ram read data, then the result queue; packet bytes give none
// throughput: one item per cycle, byte or read, while the four-entry result queue has room
// the ring is one memory with a single write and a single registered read port
// reset: asynchronous, clears pointers, parse state and queue; rate returns to 48000;
// the ring contents are not cleared and no clearing pass is needed
// depends on vad_pkg, vad_if, vad_ram, vad_front, vad_back
`timescale 1ns / 1ps
`default_nettype none
module vban_audio_depacketizer_top #(
    parameter int RING_FRAMES = 4096
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    vad_item_if.sink     items,
    vad_result_if.source results
);
    import vad_pkg::*;

    localparam int AW = $clog2(RING_FRAMES);

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [31:0]   ram_wdata, ram_rdata;
    logic          req_valid;
    read_desc_t    req;
    back_status_t  status;

    // parser and pointer logic
    vad_front #(.RING_FRAMES(RING_FRAMES)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (items),
        .status    (status),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .req_valid (req_valid),
        .req       (req)
    );

    // frame ring
    vad_ram #(.WIDTH(32), .DEPTH(RING_FRAMES)) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // result queue
    vad_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req       (req),
        .rdata     (ram_rdata),
        .status    (status),
        .results   (results)
    );
endmodule
`default_nettype wire

FILE: rtl/vad_ram.sv
// vad_ram: generic simple dual port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module vad_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end
endmodule
`default_nettype wire

FILE: rtl/vad_front.sv
// vad_front: accepts items, parses packet bytes, owns ring pointers, issues reads
// depends on vad_pkg, vad_if
`timescale 1ns / 1ps
`default_nettype none
module vad_front #(
    parameter int RING_FRAMES = 4096
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    vad_item_if.sink                            items,
    input  wire vad_pkg::back_status_t          status,
    output logic                                ram_we,
    output logic [$clog2(RING_FRAMES)-1:0]      ram_waddr,
    output logic [31:0]                         ram_wdata,
    output logic [$clog2(RING_FRAMES)-1:0]      ram_raddr,
    output logic                                req_valid,
    output vad_pkg::read_desc_t                 req
);
    import vad_pkg::*;

    localparam int AW = $clog2(RING_FRAMES);
    localparam logic [AW-1:0] LAST_IDX = AW'(RING_FRAMES - 1);
    localparam logic [AW:0]   RING_W   = (AW+1)'(RING_FRAMES);

    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW-1:0] cm_ptr_reg, cm_ptr_next;
    logic [AW-1:0] pd_ptr_reg, pd_ptr_next;
    logic [4:0]    cnt_reg, cnt_next;
    logic [7:0]    head_reg [3];
    logic [7:0]    head_next [3];
    kind_t         kind_reg, kind_next;
    logic [8:0]    fexp_reg, fexp_next;
    logic [8:0]    chans_reg, chans_next;
    logic [8:0]    chidx_reg, chidx_next;
    logic [7:0]    low_reg, low_next;
    logic [15:0]   held_reg, held_next;
    logic [19:0]   rate_reg, rate_next;

    logic          accept;
    logic          push;
    logic [15:0]   push_l, push_r;
    logic [15:0]   smp;
    logic [AW-1:0] pd_inc, rd_inc;
    logic [AW:0]   stored_w;
    logic [7:0]    b;

    // room for one more read counts the queue and the read in flight
    assign items.ready = status.level < 3'(QUEUE_DEPTH);
    assign accept      = items.valid && items.ready;
    assign b           = items.data_byte;
    assign smp         = {b, low_reg};
    assign pd_inc      = (pd_ptr_reg == LAST_IDX) ? '0 : pd_ptr_reg + 1'b1;

    // packet parsing
    always_comb
    begin
        cnt_next   = cnt_reg;
        head_next  = head_reg;
        kind_next  = kind_reg;
        fexp_next  = fexp_reg;
        chans_next = chans_reg;
        chidx_next = chidx_reg;
        low_next   = low_reg;
        held_next  = held_reg;
        rate_next  = rate_reg;
        cm_ptr_next = cm_ptr_reg;
        push       = 1'b0;
        push_l     = '0;
        push_r     = '0;
        if (accept && !items.command)
        begin
            unique case (kind_reg)
                KIND_UNDECIDED:
                begin
                    if (cnt_reg < 5'd3)
                    begin
                        head_next[cnt_reg[1:0]] = b;
                        cnt_next = cnt_reg + 1'b1;
                    end
                    else if (head_reg[0] == "V" && head_reg[1] == "B" &&
                             head_reg[2] == "A" && b == "N")
                    begin
                        kind_next = KIND_VBAN;
                        cnt_next  = 5'd4;
                    end
                    else
                    begin
                        kind_next = KIND_RAW;
                        rate_next = DEFAULT_RATE;
                        push      = 1'b1;
                        push_l    = {head_reg[1], head_reg[0]};
                        push_r    = {b, head_reg[2]};
                        cnt_next  = '0;
                    end
                end
                KIND_VBAN:
                begin
                    if (cnt_reg < 5'(HEADER_BYTES))
                    begin
                        if (cnt_reg == 5'd4)
                        begin
                            if (b[4:0] <= 5'd20)
                            begin
                                rate_next = rate_lookup(b[4:0]);
                            end
                        end
                        else if (cnt_reg == 5'd5)
                        begin
                            fexp_next = {1'b0, b} + 9'd1;
                        end
                        else if (cnt_reg == 5'd6)
                        begin
                            chans_next = {1'b0, b} + 9'd1;
                        end
                        cnt_next = cnt_reg + 1'b1;
                    end
                    else if (fexp_reg != '0 && chans_reg != '0)
                    begin
                        if (cnt_reg == 5'(HEADER_BYTES))
                        begin
                            low_next = b;
                            cnt_next = 5'(HEADER_BYTES + 1);
                        end
                        else
                        begin
                            cnt_next = 5'(HEADER_BYTES);
                            if (chidx_reg == 9'd0)
                            begin
                                held_next = smp;
                                if (chans_reg == 9'd1)
                                begin
                                    push   = 1'b1;
                                    push_l = smp;
                                    push_r = smp;
                                end
                            end
                            else if (chidx_reg == 9'd1)
                            begin
                                push   = 1'b1;
                                push_l = held_reg;
                                push_r = smp;
                            end
                            if (chidx_reg + 9'd1 >= chans_reg)
                            begin
                                chidx_next = '0;
                                fexp_next  = fexp_reg - 9'd1;
                            end
                            else
                            begin
                                chidx_next = chidx_reg + 9'd1;
                            end
                        end
                    end
                end
                default:
                begin
                    case (cnt_reg[1:0])
                        2'd0:    low_next  = b;
                        2'd1:    held_next = smp;
                        2'd2:    low_next  = b;
                        default:
                        begin
                            push   = 1'b1;
                            push_l = held_reg;
                            push_r = smp;
                        end
                    endcase
                    cnt_next = {3'b0, cnt_reg[1:0] + 2'd1};
                end
            endcase
        end
    end

    // ring write and pending pointer
    assign ram_we    = push && (pd_inc != rd_ptr_reg);
    assign ram_waddr = pd_ptr_reg;
    assign ram_wdata = {push_r, push_l};
    assign pd_ptr_next = ram_we ? pd_inc : pd_ptr_reg;

    // read side
    assign ram_raddr = rd_ptr_reg;
    assign rd_inc    = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        req_valid   = accept && items.command;
        req.valid   = req_valid && (rd_ptr_reg != cm_ptr_reg);
        if (req.valid)
        begin
            rd_ptr_next = rd_inc;
        end
        if (cm_ptr_reg >= rd_ptr_next)
        begin
            stored_w = {1'b0, cm_ptr_reg} - {1'b0, rd_ptr_next};
        end
        else
        begin
            stored_w = {1'b0, cm_ptr_reg} + RING_W - {1'b0, rd_ptr_next};
        end
        req.rate   = rate_reg;
        req.stored = 12'(32'(stored_w));
    end

    // state registers, packet end clears parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            cm_ptr_reg <= '0;
            pd_ptr_reg <= '0;
            cnt_reg    <= '0;
            head_reg   <= '{default: '0};
            kind_reg   <= KIND_UNDECIDED;
            fexp_reg   <= '0;
            chans_reg  <= '0;
            chidx_reg  <= '0;
            low_reg    <= '0;
            held_reg   <= '0;
            rate_reg   <= DEFAULT_RATE;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            pd_ptr_reg <= pd_ptr_next;
            if (accept && !items.command && items.last_byte)
            begin
                cm_ptr_reg <= pd_ptr_next;
                rate_reg   <= (kind_next == KIND_UNDECIDED) ? DEFAULT_RATE : rate_next;
                cnt_reg    <= '0;
                head_reg   <= '{default: '0};
                kind_reg   <= KIND_UNDECIDED;
                fexp_reg   <= '0;
                chans_reg  <= '0;
                chidx_reg  <= '0;
                low_reg    <= '0;
                held_reg   <= '0;
            end
            else
            begin
                cm_ptr_reg <= cm_ptr_next;
                rate_reg   <= rate_next;
                cnt_reg    <= cnt_next;
                head_reg   <= head_next;
                kind_reg   <= kind_next;
                fexp_reg   <= fexp_next;
                chans_reg  <= chans_next;
                chidx_reg  <= chidx_next;
                low_reg    <= low_next;
                held_reg   <= held_next;
            end
        end
    end
endmodule
`default_nettype wire

FILE: rtl/vad_back.sv
// vad_back: joins ram read data to read requests and queues result items
// depends on vad_pkg, vad_if
`timescale 1ns / 1ps
`default_nettype none
module vad_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 req_valid,
    input  wire vad_pkg::read_desc_t  req,
    input  wire logic [31:0]          rdata,
    output vad_pkg::back_status_t     status,
    vad_result_if.source              results
);
    import vad_pkg::*;

    localparam int QW = $clog2(QUEUE_DEPTH);

    logic              s1_valid_reg;
    read_desc_t        s1_desc_reg;
    result_t           q_reg [QUEUE_DEPTH];
    logic [QW-1:0]     wp_reg, rp_reg;
    logic [QW:0]       cnt_reg;
    result_t           entry;
    logic              pop;

    // ram read data arrives in the cycle after the request, together with the registered request
    always_comb
    begin
        entry.left_sample    = s1_desc_reg.valid ? rdata[15:0]  : '0;
        entry.right_sample   = s1_desc_reg.valid ? rdata[31:16] : '0;
        entry.frame_valid    = s1_desc_reg.valid;
        entry.stream_rate_hz = s1_desc_reg.rate;
        entry.frames_stored  = s1_desc_reg.stored;
    end

    assign pop          = results.valid && results.ready;
    // queued items plus the one still waiting for ram data
    assign status.level = cnt_reg + {{QW{1'b0}}, s1_valid_reg};

    // queue head drives the result channel
    assign results.valid          = cnt_reg != '0;
    assign results.left_sample    = q_reg[rp_reg].left_sample;
    assign results.right_sample   = q_reg[rp_reg].right_sample;
    assign results.frame_valid    = q_reg[rp_reg].frame_valid;
    assign results.stream_rate_hz = q_reg[rp_reg].stream_rate_hz;
    assign results.frames_stored  = q_reg[rp_reg].frames_stored;

    // queue payload
    always_ff @(posedge clk)
    begin
        if (req_valid)
        begin
            s1_desc_reg <= req;
        end
        if (s1_valid_reg)
        begin
            q_reg[wp_reg] <= entry;
        end
    end

    // queue control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            wp_reg       <= '0;
            rp_reg       <= '0;
            cnt_reg      <= '0;
        end
        else
        begin
            s1_valid_reg <= req_valid;
            if (s1_valid_reg)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + {{QW{1'b0}}, s1_valid_reg} - {{QW{1'b0}}, pop};
        end
    end
endmodule
`default_nettype wire

FILE: test/testbench.sv
// testbench for vban_audio_depacketizer_top: drives packet bytes and frame reads,
// predicts each read result from a behavioural copy of the ring and parser
// depends on vad_pkg, vad_if and the block's rtl
`timescale 1ns / 1ps
module testbench;
    import vad_pkg::*;

    localparam int RING = 4096;
    localparam int STALL_LIMIT = 2000;

    typedef struct {
        logic        cmd;
        logic [7:0]  data;
        logic        last;
        logic        known;
        result_t     res;
    } stim_row_t;

    logic clk;
    logic rst_n;

    vad_item_if   items();
    vad_result_if results();

    vban_audio_depacketizer_top #(.RING_FRAMES(RING)) i_dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items),
        .results (results)
    );

    // predictor state
    logic [31:0] ring_mem [RING];
    int unsigned rd_ptr, commit_ptr, pend_ptr;
    int unsigned byte_pos;
    logic [7:0]  head [4];
    kind_t       kind;
    int unsigned frames_left, chan_count, chan_idx;
    logic [7:0]  low_byte;
    logic [15:0] left_hold;
    logic [19:0] rate_now;

    result_t     frame_results [$];
    int          error_count;
    int          reads_done;
    int          valid_reads;
    int          idle_cycles;
    int          items_sent;
    logic [7:0]  byte_or;
    logic [7:0]  byte_and;
    stim_row_t   rows [$];

    // clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic logic [19:0] rate_of(input logic [4:0] idx);
        logic [19:0] tbl [21];
        tbl = '{20'd6000, 20'd12000, 20'd24000, 20'd48000, 20'd96000, 20'd192000,
                20'd384000, 20'd8000, 20'd16000, 20'd32000, 20'd64000, 20'd128000,
                20'd256000, 20'd512000, 20'd11025, 20'd22050, 20'd44100, 20'd88200,
                20'd176400, 20'd352800, 20'd705600};
        return tbl[idx];
    endfunction

    task automatic ring_push(input logic [15:0] l, input logic [15:0] r);
        int unsigned n;
        n = (pend_ptr + 1 >= RING) ? 0 : pend_ptr + 1;
        if (n != rd_ptr)
        begin
            ring_mem[pend_ptr] = {r, l};
            pend_ptr = n;
        end
    endtask

    task automatic parse_clear();
        byte_pos = 0;
        head = '{8'd0, 8'd0, 8'd0, 8'd0};
        kind = KIND_UNDECIDED;
        frames_left = 0;
        chan_count = 0;
        chan_idx = 0;
        low_byte = 8'd0;
        left_hold = 16'd0;
    endtask

    task automatic vban_take(input logic [7:0] b);
        logic [15:0] s;
        if (byte_pos < HEADER_BYTES)
        begin
            if (byte_pos == 4 && b[4:0] <= 5'd20)
                rate_now = rate_of(b[4:0]);
            else if (byte_pos == 5)
                frames_left = b + 1;
            else if (byte_pos == 6)
                chan_count = b + 1;
            byte_pos++;
        end
        else if (frames_left != 0 && chan_count != 0)
        begin
            if (byte_pos == HEADER_BYTES)
            begin
                low_byte = b;
                byte_pos = HEADER_BYTES + 1;
            end
            else
            begin
                byte_pos = HEADER_BYTES;
                s = {b, low_byte};
                if (chan_idx == 0)
                begin
                    left_hold = s;
                    if (chan_count == 1)
                        ring_push(s, s);
                end
                else if (chan_idx == 1)
                    ring_push(left_hold, s);
                chan_idx++;
                if (chan_idx >= chan_count)
                begin
                    chan_idx = 0;
                    frames_left--;
                end
            end
        end
    endtask

    // packet byte into the predictor
    task automatic predict_byte(input logic [7:0] b, input logic last);
        if (kind == KIND_UNDECIDED)
        begin
            head[byte_pos & 3] = b;
            byte_pos++;
            if (byte_pos >= 4)
            begin
                if (head[0] == "V" && head[1] == "B" && head[2] == "A" && head[3] == "N")
                begin
                    kind = KIND_VBAN;
                    byte_pos = 4;
                end
                else
                begin
                    kind = KIND_RAW;
                    rate_now = DEFAULT_RATE;
                    ring_push({head[1], head[0]}, {head[3], head[2]});
                    byte_pos = 0;
                end
            end
        end
        else if (kind == KIND_VBAN)
            vban_take(b);
        else
        begin
            case (byte_pos & 3)
                0: low_byte = b;
                1: left_hold = {b, low_byte};
                2: low_byte = b;
                default: ring_push(left_hold, {b, low_byte});
            endcase
            byte_pos = (byte_pos + 1) & 3;
        end
        if (last)
        begin
            if (kind == KIND_UNDECIDED)
                rate_now = DEFAULT_RATE;
            commit_ptr = pend_ptr;
            parse_clear();
        end
    endtask

    function automatic result_t predict_read();
        result_t r;
        r = '0;
        if (rd_ptr != commit_ptr)
        begin
            r.left_sample = ring_mem[rd_ptr][15:0];
            r.right_sample = ring_mem[rd_ptr][31:16];
            r.frame_valid = 1'b1;
            rd_ptr = (rd_ptr + 1 >= RING) ? 0 : rd_ptr + 1;
        end
        r.stream_rate_hz = rate_now;
        r.frames_stored = 12'((commit_ptr >= rd_ptr) ? commit_ptr - rd_ptr
                                                     : commit_ptr + RING - rd_ptr);
        return r;
    endfunction

    // send one item, wait for acceptance, then update the prediction
    task automatic send_item(input logic cmd, input logic [7:0] b, input logic last,
                             input logic known, input result_t want);
        int gap;
        result_t r;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
        repeat (gap)
        begin
            items.valid <= 1'b0;
            @(posedge clk);
        end
        items.valid <= 1'b1;
        items.command <= cmd;
        items.data_byte <= b;
        items.last_byte <= last;
        do
            @(posedge clk);
        while (!items.ready);
        items_sent++;
        if (cmd)
        begin
            r = predict_read();
            if (known && r != want)
            begin
                $display("%0t table row mismatch: expected %h actual prediction %h",
                         $time, want, r);
                error_count++;
            end
            frame_results.push_back(r);
        end
        else
        begin
            byte_or |= b;
            byte_and &= b;
            predict_byte(b, last);
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        send_item(1'b0, b, last, 1'b0, '0);
    endtask

    task automatic send_read();
        send_item(1'b1, 8'($urandom), 1'($urandom), 1'b0, '0);
    endtask

    task automatic send_vban(input int nbs, input int nbc, input logic [7:0] rate_byte,
                             input int cut);
        int total;
        total = 28 + (nbs + 1) * (nbc + 1) * 2 + cut;
        if (total < 1)
            total = 1;
        for (int i = 0; i < total; i++)
        begin
            logic [7:0] b;
            case (i)
                0: b = "V";
                1: b = "B";
                2: b = "A";
                3: b = "N";
                4: b = rate_byte;
                5: b = 8'(nbs);
                6: b = 8'(nbc);
                default: b = 8'($urandom);
            endcase
            send_byte(b, i == total - 1);
        end
    endtask

    task automatic send_raw(input int len);
        for (int i = 0; i < len; i++)
            send_byte(i == 0 ? 8'($urandom_range(0, 85)) : 8'($urandom), i == len - 1);
    endtask

    task automatic add_row(input logic cmd, input logic [7:0] b, input logic last,
                           input logic known, input result_t want);
        stim_row_t s;
        s.cmd = cmd;
        s.data = b;
        s.last = last;
        s.known = known;
        s.res = want;
        rows.push_back(s);
    endtask

    // result side: a random wait after each item and comparison with the oldest expectation
    initial
    begin
        int stall;
        result_t got;
        stall = 0;
        results.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (results.valid && results.ready)
            begin
                got = '{results.left_sample, results.right_sample, results.frame_valid,
                        results.stream_rate_hz, results.frames_stored};
                reads_done++;
                if (got.frame_valid)
                    valid_reads++;
                if (frame_results.size() == 0)
                begin
                    $display("%0t unexpected frame: expected none actual %h", $time, got);
                    error_count++;
                end
                else
                begin
                    result_t w;
                    w = frame_results.pop_front();
                    if (got.left_sample !== w.left_sample)
                    begin
                        $display("%0t left_sample: expected %h actual %h",
                                 $time, w.left_sample, got.left_sample);
                        error_count++;
                    end
                    if (got.right_sample !== w.right_sample)
                    begin
                        $display("%0t right_sample: expected %h actual %h",
                                 $time, w.right_sample, got.right_sample);
                        error_count++;
                    end
                    if (got.frame_valid !== w.frame_valid)
                    begin
                        $display("%0t frame_valid: expected %b actual %b",
                                 $time, w.frame_valid, got.frame_valid);
                        error_count++;
                    end
                    if (got.stream_rate_hz !== w.stream_rate_hz)
                    begin
                        $display("%0t stream_rate_hz: expected %0d actual %0d",
                                 $time, w.stream_rate_hz, got.stream_rate_hz);
                        error_count++;
                    end
                    if (got.frames_stored !== w.frames_stored)
                    begin
                        $display("%0t frames_stored: expected %0d actual %0d",
                                 $time, w.frames_stored, got.frames_stored);
                        error_count++;
                    end
                end
                stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
            end
            else if (stall > 0)
                stall--;
            results.ready <= (stall == 0);
        end
    end

    // watchdog on cycles with no handshake on either side
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((items.valid && items.ready) || (results.valid && results.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // stimulus
    initial
    begin
        result_t z;
        int waited;
        items.valid = 1'b0;
        items.command = 1'b0;
        items.data_byte = 8'd0;
        items.last_byte = 1'b0;
        rst_n = 1'b0;
        error_count = 0;
        reads_done = 0;
        valid_reads = 0;
        items_sent = 0;
        byte_or = 8'h00;
        byte_and = 8'hff;
        rd_ptr = 0;
        commit_ptr = 0;
        pend_ptr = 0;
        rate_now = DEFAULT_RATE;
        parse_clear();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table: empty read, short packet, raw with partial frame; then vban
        // mono, multichannel with out of range rate index, and stereo
        z = '0;
        z.stream_rate_hz = DEFAULT_RATE;
        add_row(1'b1, 8'hff, 1'b1, 1'b1, z);
        add_row(1'b0, 8'h00, 1'b0, 1'b0, z);
        add_row(1'b0, 8'hff, 1'b1, 1'b0, z);
        add_row(1'b1, 8'h00, 1'b0, 1'b1, z);
        // raw: frame 8000/7fff then a dropped partial frame
        add_row(1'b0, 8'h00, 1'b0, 1'b0, z);
        add_row(1'b0, 8'h80, 1'b0, 1'b0, z);
        add_row(1'b0, 8'hff, 1'b0, 1'b0, z);
        add_row(1'b0, 8'h7f, 1'b0, 1'b0, z);
        add_row(1'b0, 8'h12, 1'b1, 1'b0, z);
        z.left_sample = 16'h8000;
        z.right_sample = 16'h7fff;
        z.frame_valid = 1'b1;
        add_row(1'b1, 8'h00, 1'b0, 1'b1, z);
        z = '0;
        z.stream_rate_hz = DEFAULT_RATE;
        add_row(1'b1, 8'h00, 1'b0, 1'b1, z);
        foreach (rows[i])
            send_item(rows[i].cmd, rows[i].data, rows[i].last, rows[i].known, rows[i].res);
        send_vban(1, 0, 8'h14, 0);
        send_read();
        send_read();
        send_vban(0, 2, 8'hff, 3);
        send_vban(2, 1, 8'h00, -3);
        send_vban(0, 1, 8'h00, -20);
        send_read();
        send_read();
        send_read();

        // random packets mixed with reads
        while (items_sent < 370 ||
               ((byte_or != 8'hff || byte_and != 8'h00) && items_sent < 440))
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: send_vban($urandom_range(0, 3), $urandom_range(0, 3),
                                      8'($urandom), $urandom_range(0, 4) == 0 ?
                                      -int'($urandom_range(1, 30)) : $urandom_range(0, 2));
                4: send_vban($urandom_range(0, 255) == 0 ? 255 : 1, $urandom_range(0, 1),
                             8'($urandom), 0);
                5, 6: send_raw($urandom_range(1, 14));
                default:
                    repeat ($urandom_range(1, 6))
                        send_read();
            endcase
        end
        // drain the ring
        while (commit_ptr != rd_ptr)
            send_read();
        send_read();
        items.valid <= 1'b0;

        waited = 0;
        while (frame_results.size() != 0 && waited < 10000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (10) @(posedge clk);
        $display("read %0d frames, %0d of them carried stored audio", reads_done, valid_reads);
        $display("packets covered vban mono/stereo/multichannel, raw and short forms");
        if (error_count == 0 && frame_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
